// File: src/ec_point_scalar_multiply_mod_unit_macros.svh
// Assertion macros used by the top module.
`ifndef EC_POINT_SCALAR_MULTIPLY_MOD_UNIT_MACROS_SVH
`define EC_POINT_SCALAR_MULTIPLY_MOD_UNIT_MACROS_SVH

// same-cycle implication
`define ECSM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ECSM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/ecsm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecsm_pkg
// Shared widths, codes and modular add/subtract helpers.
// ----------------------------------------------------------------------------
package ecsm_pkg;

	localparam int WIDTH        = 32;
	localparam int SCALAR_WIDTH = 32;
	localparam int CNT_W        = $clog2(WIDTH);
	localparam int CFG_IDX_W    = 1;

	localparam logic [CFG_IDX_W-1:0] REG_MODULUS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CURVE_A = 1'd1;

	localparam logic [1:0] STATUS_FINITE = 2'd0;
	localparam logic [1:0] STATUS_INF    = 2'd1;
	localparam logic [1:0] STATUS_FAIL   = 2'd2;

	typedef logic [WIDTH-1:0] word_t;

	typedef enum logic {ALU_MUL, ALU_DIV} alu_op_t;

	typedef struct packed {
		logic    start;
		alu_op_t op;
	} alu_req_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_RED_A, ST_RED_X, ST_RED_Y, ST_STEP, ST_SHIFT, ST_ADD,
		ST_SQ, ST_NUM1, ST_NUM2, ST_INV_INIT, ST_INV_CHK, ST_DIV, ST_QT,
		ST_LAM, ST_LL, ST_X3, ST_Y3M, ST_FIN, ST_DONE
	} state_t;

	function automatic word_t mod_add(word_t a, word_t b, word_t m);
		logic [WIDTH:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= {1'b0, m})
			s = s - {1'b0, m};
		return s[WIDTH-1:0];
	endfunction

	function automatic word_t mod_sub(word_t a, word_t b, word_t m);
		word_t d;
		d = a - b;
		if (a < b)
			d = d + m;
		return d;
	endfunction

endpackage

// File: src/ecsm_serial_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecsm_serial_alu
// Bit-serial modular multiplier and restoring divider, one bit per cycle.
// ----------------------------------------------------------------------------
module ecsm_serial_alu
	import ecsm_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  alu_req_t req,
	input  word_t    op_a,
	input  word_t    op_b,
	input  word_t    m,
	output logic     done,
	output word_t    res,
	output word_t    rem
);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	alu_op_t          op_q;
	word_t            a_q;
	word_t            b_q;
	word_t            m_q;
	word_t            r_q;

	word_t          mul_dbl;
	word_t          mul_nxt;
	logic [WIDTH:0] div_cat;
	logic           div_ge;
	word_t          div_nxt;

	always_comb begin
		mul_dbl = mod_add(r_q, r_q, m_q);
		mul_nxt = b_q[WIDTH-1] ? mod_add(mul_dbl, a_q, m_q) : mul_dbl;
		div_cat = {r_q, a_q[WIDTH-1]};
		div_ge  = div_cat >= {1'b0, b_q};
		div_nxt = div_ge ? WIDTH'(div_cat - {1'b0, b_q}) : div_cat[WIDTH-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(WIDTH - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			op_q <= req.op;
			a_q  <= op_a;
			b_q  <= op_b;
			m_q  <= m;
			r_q  <= '0;
		end else if (busy_q) begin
			if (op_q == ALU_MUL) begin
				r_q <= mul_nxt;
				b_q <= {b_q[WIDTH-2:0], 1'b0};
			end else begin
				r_q <= div_nxt;
				a_q <= {a_q[WIDTH-2:0], div_ge};
			end
		end
	end

	assign done = done_q;
	assign res  = (op_q == ALU_MUL) ? r_q : a_q;
	assign rem  = r_q;

endmodule

// File: src/ec_point_scalar_multiply_mod_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ec_point_scalar_multiply_mod_unit
// Affine double-and-add scalar multiply modulo a configured modulus.
// ----------------------------------------------------------------------------
// Input channel: scalar, point_x, point_y, point_at_infinity, taken on
// in_valid && !in_stall. Output channel: result_x, result_y, status,
// bad_denominator, common_factor, delivered on out_valid && !out_stall.
// Config channel: cfg_index 0 = modulus, 1 = curve_a, written on
// cfg_valid && cfg_ready; ready is always high.
// One item at a time: in_stall is high from acceptance until its result
// is taken. Every multiply, remainder or Euclid quotient runs on one
// shared bit-serial unit. Reduction of the inputs takes three remainders;
// an addition takes 3 multiplies and a doubling 4, plus a division and a
// multiply per Euclid step (up to ~47 steps) of the inverse.
// A modulus below 2 shows status 1 on the cycle after acceptance.
// The result stays on the output while out_stall is high.
// Reset sets modulus to 3, curve_a to 0 and returns to idle.
// ----------------------------------------------------------------------------
`include "ec_point_scalar_multiply_mod_unit_macros.svh"

module ec_point_scalar_multiply_mod_unit
	import ecsm_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [SCALAR_WIDTH-1:0] scalar,
	input  logic [WIDTH-1:0]        point_x,
	input  logic [WIDTH-1:0]        point_y,
	input  logic                    point_at_infinity,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [WIDTH-1:0]        result_x,
	output logic [WIDTH-1:0]        result_y,
	output logic [1:0]              status,
	output logic [WIDTH-1:0]        bad_denominator,
	output logic [WIDTH-1:0]        common_factor,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [WIDTH-1:0]        cfg_data
);

	state_t state_q, state_d;

	word_t modulus_q, curve_a_q, a_q;
	word_t px_q, py_q, ax_q, ay_q;
	logic  pf_q, af_q, dbl_q;
	logic [SCALAR_WIDTH-1:0] k_q;
	word_t num_q, den_q, r0_q, r1_q, t0_q, t1_q, lam_q, tmp_q, x3_q;
	word_t rx_q, ry_q, bad_q, cf_q;
	logic [1:0] st_q;
	logic issued_q;

	alu_req_t alu_req;
	word_t    alu_a, alu_b, alu_res, alu_rem;
	logic     alu_done;
	logic     compute;

	word_t qx, qy;
	logic  qf;
	logic  commit;
	word_t cx, cy;
	logic  cf;
	logic  in_acc;

	assign in_acc    = in_valid && !in_stall;
	assign in_stall  = state_q != ST_IDLE;
	assign out_valid = state_q == ST_DONE;
	assign cfg_ready = 1'b1;
	assign result_x        = rx_q;
	assign result_y        = ry_q;
	assign status          = st_q;
	assign bad_denominator = bad_q;
	assign common_factor   = cf_q;

	assign qx = dbl_q ? px_q : ax_q;
	assign qy = dbl_q ? py_q : ay_q;
	assign qf = dbl_q ? pf_q : af_q;

	ecsm_serial_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.op_a   (alu_a),
		.op_b   (alu_b),
		.m      (modulus_q),
		.done   (alu_done),
		.res    (alu_res),
		.rem    (alu_rem)
	);

	// outputs of the sequencer: unit request and point commit
	always_comb begin
		compute = 1'b0;
		alu_req.op = ALU_MUL;
		alu_a = px_q;
		alu_b = px_q;
		commit = 1'b0;
		cx = px_q;
		cy = py_q;
		cf = pf_q;
		case (state_q)
			ST_RED_A: begin
				compute = 1'b1; alu_req.op = ALU_DIV; alu_a = curve_a_q; alu_b = modulus_q;
			end
			ST_RED_X: begin
				compute = 1'b1; alu_req.op = ALU_DIV; alu_a = px_q; alu_b = modulus_q;
			end
			ST_RED_Y: begin
				compute = 1'b1; alu_req.op = ALU_DIV; alu_a = py_q; alu_b = modulus_q;
			end
			ST_SQ: compute = 1'b1;
			ST_DIV: begin
				compute = 1'b1; alu_req.op = ALU_DIV; alu_a = r0_q; alu_b = r1_q;
			end
			ST_QT: begin
				compute = 1'b1; alu_a = tmp_q; alu_b = t1_q;
			end
			ST_LAM: begin
				compute = 1'b1; alu_a = num_q; alu_b = t0_q;
			end
			ST_LL: begin
				compute = 1'b1; alu_a = lam_q; alu_b = lam_q;
			end
			ST_Y3M: begin
				compute = 1'b1; alu_a = lam_q; alu_b = mod_sub(px_q, x3_q, modulus_q);
				if (alu_done) begin
					commit = 1'b1;
					cx = x3_q;
					cy = mod_sub(alu_res, py_q, modulus_q);
					cf = 1'b1;
				end
			end
			ST_ADD: begin
				if (!pf_q) begin
					commit = 1'b1; cx = qx; cy = qy; cf = qf;
				end else if (!qf) begin
					commit = 1'b1;
				end else if (px_q == qx && mod_add(py_q, qy, modulus_q) == '0) begin
					commit = 1'b1; cx = '0; cy = '0; cf = 1'b0;
				end
			end
			default: ;
		endcase
		alu_req.start = compute && !issued_q && !alu_done;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:
				if (in_acc)
					state_d = (modulus_q < WIDTH'(2)) ? ST_DONE : ST_RED_A;
			ST_RED_A: if (alu_done) state_d = ST_RED_X;
			ST_RED_X: if (alu_done) state_d = ST_RED_Y;
			ST_RED_Y: if (alu_done) state_d = ST_STEP;
			ST_STEP:
				if (k_q == '0)
					state_d = ST_FIN;
				else
					state_d = k_q[0] ? ST_ADD : ST_SHIFT;
			ST_SHIFT: state_d = ((k_q >> 1) == '0) ? ST_FIN : ST_ADD;
			ST_ADD:
				if (commit)
					state_d = dbl_q ? ST_STEP : ST_SHIFT;
				else if (px_q == qx)
					state_d = ST_SQ;
				else
					state_d = ST_INV_INIT;
			ST_SQ:       if (alu_done) state_d = ST_NUM1;
			ST_NUM1:     state_d = ST_NUM2;
			ST_NUM2:     state_d = ST_INV_INIT;
			ST_INV_INIT: state_d = ST_INV_CHK;
			ST_INV_CHK:
				if (r1_q != '0)
					state_d = ST_DIV;
				else
					state_d = (r0_q != WIDTH'(1)) ? ST_DONE : ST_LAM;
			ST_DIV: if (alu_done) state_d = ST_QT;
			ST_QT:  if (alu_done) state_d = ST_INV_CHK;
			ST_LAM: if (alu_done) state_d = ST_LL;
			ST_LL:  if (alu_done) state_d = ST_X3;
			ST_X3:  state_d = ST_Y3M;
			ST_Y3M: if (alu_done) state_d = dbl_q ? ST_STEP : ST_SHIFT;
			ST_FIN:  state_d = ST_DONE;
			ST_DONE: if (!out_stall) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			issued_q  <= 1'b0;
			modulus_q <= WIDTH'(3);
			curve_a_q <= '0;
		end else begin
			state_q <= state_d;
			if (alu_req.start)
				issued_q <= 1'b1;
			else if (alu_done)
				issued_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_MODULUS: modulus_q <= cfg_data;
					REG_CURVE_A: curve_a_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			if (dbl_q) begin
				px_q <= cx; py_q <= cy; pf_q <= cf;
			end else begin
				ax_q <= cx; ay_q <= cy; af_q <= cf;
			end
		end
		case (state_q)
			ST_IDLE:
				if (in_acc) begin
					k_q <= scalar; px_q <= point_x; py_q <= point_y;
					pf_q <= !point_at_infinity;
					ax_q <= '0; ay_q <= '0; af_q <= 1'b0;
					rx_q <= '0; ry_q <= '0; st_q <= STATUS_INF;
					bad_q <= '0; cf_q <= '0;
				end
			ST_RED_A: if (alu_done) a_q  <= alu_rem;
			ST_RED_X: if (alu_done) px_q <= alu_rem;
			ST_RED_Y: if (alu_done) py_q <= alu_rem;
			ST_STEP:  dbl_q <= 1'b0;
			ST_SHIFT: begin
				k_q <= k_q >> 1;
				dbl_q <= 1'b1;
			end
			ST_ADD:
				if (px_q == qx) begin
					den_q <= mod_add(py_q, py_q, modulus_q);
				end else begin
					num_q <= mod_sub(qy, py_q, modulus_q);
					den_q <= mod_sub(qx, px_q, modulus_q);
				end
			ST_SQ:
				if (alu_done) begin
					tmp_q <= alu_res;
					num_q <= mod_add(alu_res, alu_res, modulus_q);
				end
			ST_NUM1: num_q <= mod_add(num_q, tmp_q, modulus_q);
			ST_NUM2: num_q <= mod_add(num_q, a_q, modulus_q);
			ST_INV_INIT: begin
				r0_q <= modulus_q; r1_q <= den_q; t0_q <= '0; t1_q <= WIDTH'(1);
			end
			ST_INV_CHK:
				if (r1_q == '0 && r0_q != WIDTH'(1)) begin
					st_q <= STATUS_FAIL; bad_q <= den_q; cf_q <= r0_q;
				end
			ST_DIV:
				if (alu_done) begin
					r0_q  <= r1_q;
					r1_q  <= alu_rem;
					tmp_q <= (alu_res == modulus_q) ? '0 : alu_res;
				end
			ST_QT:
				if (alu_done) begin
					t0_q <= t1_q;
					t1_q <= mod_sub(t0_q, alu_res, modulus_q);
				end
			ST_LAM: if (alu_done) lam_q <= alu_res;
			ST_LL:  if (alu_done) tmp_q <= mod_sub(alu_res, px_q, modulus_q);
			ST_X3:  x3_q <= mod_sub(tmp_q, qx, modulus_q);
			ST_FIN:
				if (af_q) begin
					rx_q <= ax_q; ry_q <= ay_q; st_q <= STATUS_FINITE;
				end
			default: ;
		endcase
	end

	`ECSM_ASSERT_NOW(a_out_blocks_in, out_valid, in_stall, "input taken while result pending")
	`ECSM_ASSERT_NOW(a_done_issued, alu_done, issued_q, "unit finished without a request")
	`ECSM_ASSERT_NOW(a_fail_factor, out_valid && status == STATUS_FAIL,
		common_factor != WIDTH'(1) && common_factor != '0, "reported factor is trivial")
	`ECSM_ASSERT_NEXT(a_accept_stalls, in_acc, in_stall, "input open right after an item")

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the elliptic-curve scalar multiply unit. A
// directed table covers the extremes, identity inputs, the small moduli and
// a forced non-invertible slope. Random items then run under several
// modulus and curve settings, checked against a behavioral double-and-add.
// ----------------------------------------------------------------------------
module tb;
	import ecsm_pkg::*;

	localparam longint CYCLE_LIMIT = 200_000_000;

	typedef struct {
		word_t      x;
		word_t      y;
		logic [1:0] st;
		word_t      bad;
		word_t      cf;
	} ecsm_result_t;

	typedef struct {
		bit           set_cfg;
		word_t        m;
		word_t        a;
		logic [31:0]  k;
		word_t        px;
		word_t        py;
		bit           inf;
		bit           typed;
		ecsm_result_t res;
	} stim_row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic [SCALAR_WIDTH-1:0] scalar = '0;
	word_t point_x = '0;
	word_t point_y = '0;
	logic point_at_infinity = 0;
	logic out_valid;
	logic out_stall = 0;
	word_t result_x, result_y, bad_denominator, common_factor;
	logic [1:0] status;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	word_t cfg_data = '0;

	ecsm_result_t expected_q[$];
	word_t shadow_m = 3;
	word_t shadow_a = 0;
	int errors = 0;
	int items_sent = 0;
	longint cycles = 0;
	bit [63:0] fail_d, fail_g;

	ec_point_scalar_multiply_mod_unit dut (.*);

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	function automatic bit [63:0] madd(bit [63:0] a, bit [63:0] b, bit [63:0] m);
		return (a + b) % m;
	endfunction

	function automatic bit [63:0] msub(bit [63:0] a, bit [63:0] b, bit [63:0] m);
		return (a >= b) ? a - b : a + (m - b);
	endfunction

	function automatic bit invert(bit [63:0] d, bit [63:0] m, output bit [63:0] inv);
		bit [63:0] r0, r1, t0, t1, q, nr, nt;
		r0 = m; r1 = d; t0 = 0; t1 = 1 % m;
		while (r1 != 0) begin
			q = r0 / r1;
			nr = r0 - q * r1;
			nt = msub(t0, ((q % m) * t1) % m, m);
			r0 = r1; r1 = nr; t0 = t1; t1 = nt;
		end
		inv = t0;
		if (r0 != 1) begin
			fail_d = d;
			fail_g = r0;
			return 0;
		end
		return 1;
	endfunction

	// returns 0 on a failed inverse
	function automatic bit point_add(bit [63:0] m, bit [63:0] a,
			bit [63:0] px, bit [63:0] py, bit pf, bit [63:0] qx, bit [63:0] qy, bit qf,
			output bit [63:0] rx, output bit [63:0] ry, output bit rf);
		bit [63:0] num, den, inv, lam, sq, x3;
		rx = qx; ry = qy; rf = qf;
		if (!pf) return 1;
		rx = px; ry = py; rf = pf;
		if (!qf) return 1;
		if (px == qx) begin
			if (madd(py, qy, m) == 0) begin
				rx = 0; ry = 0; rf = 0;
				return 1;
			end
			sq = (px * px) % m;
			num = madd(madd(madd(sq, sq, m), sq, m), a, m);
			den = madd(py, py, m);
		end else begin
			num = msub(qy, py, m);
			den = msub(qx, px, m);
		end
		if (!invert(den, m, inv)) return 0;
		lam = (num * inv) % m;
		x3 = msub(msub((lam * lam) % m, px, m), qx, m);
		rx = x3;
		ry = msub((lam * msub(px, x3, m)) % m, py, m);
		rf = 1;
		return 1;
	endfunction

	function automatic ecsm_result_t scalar_multiply(logic [31:0] k_in, word_t x_in,
			word_t y_in, bit inf_in);
		ecsm_result_t r;
		bit [63:0] m, a, px, py, ax, ay, tx, ty;
		bit pf, af, tf;
		logic [31:0] k;
		r = '{x: 0, y: 0, st: STATUS_INF, bad: 0, cf: 0};
		if (shadow_m < 2) return r;
		m = 64'(shadow_m);
		a = 64'(shadow_a) % m;
		px = 64'(x_in) % m; py = 64'(y_in) % m; pf = !inf_in;
		ax = 0; ay = 0; af = 0;
		k = k_in;
		while (k != 0) begin
			if (k[0]) begin
				if (!point_add(m, a, px, py, pf, ax, ay, af, tx, ty, tf)) begin
					r.st = STATUS_FAIL; r.bad = fail_d[WIDTH-1:0]; r.cf = fail_g[WIDTH-1:0];
					return r;
				end
				ax = tx; ay = ty; af = tf;
			end
			k = k >> 1;
			if (k == 0) break;
			if (!point_add(m, a, px, py, pf, px, py, pf, tx, ty, tf)) begin
				r.st = STATUS_FAIL; r.bad = fail_d[WIDTH-1:0]; r.cf = fail_g[WIDTH-1:0];
				return r;
			end
			px = tx; py = ty; pf = tf;
		end
		if (af) begin
			r.x = ax[WIDTH-1:0]; r.y = ay[WIDTH-1:0]; r.st = STATUS_FINITE;
		end
		return r;
	endfunction

	function automatic int sender_idle_pct();
		if (items_sent < 38) return 30;
		if (items_sent < 76) return 80;
		return 0;
	endfunction

	always @(negedge clk) begin
		int pct;
		pct = (items_sent < 38) ? 80 : (items_sent < 76) ? 30 : 0;
		out_stall <= ($urandom_range(99) < pct);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: done, errors");
			$finish;
		end
	end

	always @(posedge clk) begin
		ecsm_result_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_q.size() == 0) begin
				$error("unexpected result item");
				errors++;
			end else begin
				e = expected_q.pop_front();
				if (result_x !== e.x) begin
					$error("result_x exp %h got %h", e.x, result_x); errors++;
				end
				if (result_y !== e.y) begin
					$error("result_y exp %h got %h", e.y, result_y); errors++;
				end
				if (status !== e.st) begin
					$error("status exp %0d got %0d", e.st, status); errors++;
				end
				if (bad_denominator !== e.bad) begin
					$error("bad_denominator exp %h got %h", e.bad, bad_denominator);
					errors++;
				end
				if (common_factor !== e.cf) begin
					$error("common_factor exp %h got %h", e.cf, common_factor); errors++;
				end
			end
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, word_t data);
		@(negedge clk);
		cfg_valid = 1; cfg_index = idx; cfg_data = data;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_MODULUS) shadow_m = data;
		else shadow_a = data;
		@(negedge clk);
		cfg_valid = 0;
	endtask

	task automatic drain();
		while (expected_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic send_item(logic [31:0] k, word_t x, word_t y, bit inf,
			bit typed, ecsm_result_t res);
		@(negedge clk);
		while ($urandom_range(99) < sender_idle_pct()) begin
			in_valid = 0;
			@(negedge clk);
		end
		in_valid = 1; scalar = k; point_x = x; point_y = y; point_at_infinity = inf;
		do @(posedge clk); while (in_stall);
		expected_q.insert(expected_q.size(), typed ? res : scalar_multiply(k, x, y, inf));
		items_sent++;
	endtask

	task automatic release_input();
		@(negedge clk);
		in_valid = 0;
	endtask

	stim_row_t directed[$];
	ecsm_result_t r_inf;

	initial begin
		logic [31:0] k;
		word_t m;
		r_inf = '{x: 0, y: 0, st: STATUS_INF, bad: 0, cf: 0};
		directed = '{
			'{0, 3, 0, 0, 1, 1, 0, 1, r_inf},
			'{0, 3, 0, 7, 5, 5, 1, 1, r_inf},
			'{0, 3, 0, 1, 32'hFFFFFFFF, 32'hFFFFFFFF, 0, 1,
				'{x: 0, y: 0, st: STATUS_FINITE, bad: 0, cf: 0}},
			'{0, 3, 0, 2, 0, 0, 0, 1, r_inf},
			'{0, 3, 0, 2, 1, 1, 0, 0, r_inf},
			'{0, 3, 0, 32'hFFFFFFFF, 1, 1, 0, 0, r_inf},
			'{0, 3, 0, 32'h80000000, 2, 1, 0, 0, r_inf},
			'{1, 0, 0, 5, 3, 4, 0, 1, r_inf},
			'{1, 1, 32'hFFFFFFFF, 32'hFFFFFFFF, 3, 4, 0, 1, r_inf},
			'{1, 15, 7, 2, 1, 3, 0, 1,
				'{x: 0, y: 0, st: STATUS_FAIL, bad: 6, cf: 3}},
			'{0, 15, 7, 1, 20, 30, 0, 1,
				'{x: 5, y: 0, st: STATUS_FINITE, bad: 0, cf: 0}},
			'{0, 15, 7, 3, 2, 5, 0, 0, r_inf},
			'{0, 15, 7, 6, 4, 9, 0, 0, r_inf},
			'{1, 32'hFFFFFFFF, 32'hFFFFFFFF, 1, 0, 32'hFFFFFFFE, 0, 1,
				'{x: 0, y: 32'hFFFFFFFE, st: STATUS_FINITE, bad: 0, cf: 0}},
			'{0, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 12345, 678, 0, 0, r_inf},
			'{0, 32'hFFFFFFFF, 32'hFFFFFFFF, 5, 32'h80000001, 32'h7FFFFFFF, 0, 0, r_inf}
		};
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		foreach (directed[i]) begin
			if (directed[i].set_cfg) begin
				release_input();
				drain();
				write_reg(REG_MODULUS, directed[i].m);
				write_reg(REG_CURVE_A, directed[i].a);
			end
			send_item(directed[i].k, directed[i].px, directed[i].py, directed[i].inf,
				directed[i].typed, directed[i].res);
		end
		for (int ph = 0; ph < 5; ph++) begin
			release_input();
			drain();
			case (ph)
				0: m = 21;
				1: m = $urandom_range(3, 3000);
				2: m = $urandom | 32'h80000001;
				3: m = 2;
				default: m = $urandom_range(3, 60000);
			endcase
			write_reg(REG_MODULUS, m);
			write_reg(REG_CURVE_A, $urandom);
			for (int n = 0; n < 20; n++) begin
				k = ($urandom_range(11) == 0) ? $urandom : $urandom_range(0, 63);
				if (m[31] && k > 63 && n > 4) k = 32'(k[7:0]);
				send_item(k, $urandom, $urandom, $urandom_range(15) == 0, 0, r_inf);
			end
		end
		release_input();
		drain();
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+src
src/ecsm_pkg.sv
src/ecsm_serial_alu.sv
src/ec_point_scalar_multiply_mod_unit.sv
bench/tb.sv
